### src/bae_pkg.sv
package bae_pkg;

    // input opcodes
    localparam logic [1:0] OP_ENCODE = 2'd0;
    localparam logic [1:0] OP_FLUSH  = 2'd1;
    localparam logic [1:0] OP_START  = 2'd2;

    // result kinds
    localparam logic KIND_BIT   = 1'b0;
    localparam logic KIND_CARRY = 1'b1;

    localparam logic [11:0] RANGE_FULL = 12'd4095;
    localparam logic [11:0] LOW_RESET  = 12'd0;

    localparam logic [7:0] PROB_MIN = 8'd1;
    localparam logic [7:0] PROB_MAX = 8'd128;

    // result count limit per encode, and bits per flush
    localparam logic [3:0] RES_LAST   = 4'd11;
    localparam logic [3:0] FLUSH_LAST = 4'd11;

    // datapath commands
    typedef logic [2:0] dp_cmd_t;
    localparam dp_cmd_t DP_HOLD   = 3'd0;
    localparam dp_cmd_t DP_START  = 3'd1;
    localparam dp_cmd_t DP_SPLIT  = 3'd2;
    localparam dp_cmd_t DP_RENORM = 3'd3;
    localparam dp_cmd_t DP_ROTATE = 3'd4;

    // datapath status towards the sequencer
    typedef struct packed {
        logic carry;        // split overflows low
        logic split_small;  // range after split needs renormalising
        logic msb;          // top bit of low
        logic shift_small;  // range after one more doubling still needs it
    } dp_stat_t;

endpackage

### src/bae_dpath.sv
module bae_dpath
    import bae_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  dp_cmd_t    cmd,
    input  logic [7:0] prob,
    input  logic       symbol,
    output dp_stat_t   stat
);

    logic [11:0] range_reg;
    logic [11:0] range_next;
    logic [11:0] low_reg;
    logic [11:0] low_next;

    logic [3:0]  k;
    logic [11:0] q;
    logic [11:0] rest;
    logic [12:0] low_sum;
    logic [11:0] split_range;

    // split point from the top range bits
    assign k           = range_reg[11:8] | {3'b000, range_reg[7]};
    assign q           = {8'd0, k} * {4'd0, prob};
    assign rest        = range_reg - q;
    assign low_sum     = {1'b0, low_reg} + {1'b0, rest};
    assign split_range = symbol ? rest : q;

    assign stat.carry       = !symbol && low_sum[12];
    assign stat.split_small = !split_range[11] && (split_range != 12'd0);
    assign stat.msb         = low_reg[11];
    assign stat.shift_small = !range_reg[10] && (range_reg[9:0] != 10'd0);

    always_comb
    begin
        range_next = range_reg;
        low_next   = low_reg;
        unique case (cmd)
            DP_HOLD:
            begin
            end
            DP_START:
            begin
                range_next = RANGE_FULL;
                low_next   = LOW_RESET;
            end
            DP_SPLIT:
            begin
                range_next = split_range;
                if (!symbol)
                begin
                    low_next = low_sum[11:0];
                end
            end
            DP_RENORM:
            begin
                range_next = {range_reg[10:0], 1'b0};
                low_next   = {low_reg[10:0], 1'b0};
            end
            DP_ROTATE:
            begin
                low_next = {low_reg[10:0], low_reg[11]};
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            range_reg <= RANGE_FULL;
            low_reg   <= LOW_RESET;
        end
        else
        begin
            range_reg <= range_next;
            low_reg   <= low_next;
        end
    end

endmodule

### src/binary_arithmetic_encoder_unit.sv
// binary arithmetic encoder, 12-bit range and 12-bit low window
// encode: takes the transfer, does the split, then emits one bit per renormalising step (0..8 bits)
// flush: takes the transfer, then emits 12 bits, one per rotation through the shift unit
// start: reloads range and low; throughput: one item at a time, s_axis_tready low while an item is in work
// output stalls hold the sequencer; asynchronous active-low reset sets range 4095, low 0
module binary_arithmetic_encoder_unit
    import bae_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // prob [7:0], symbol [8], zero fill
    input  logic [1:0]  s_axis_tuser,   // opcode [1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // out_bit [0], zero fill
    output logic        m_axis_tuser,   // kind [0]
    output logic        m_axis_tlast
);

    // sequencer states
    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SPLIT  = 2'd1;
    localparam logic [1:0] ST_RENORM = 2'd2;
    localparam logic [1:0] ST_FLUSH  = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic [3:0] cnt_reg;
    logic [3:0] cnt_next;
    logic [7:0] prob_reg;
    logic       symbol_reg;

    logic       out_valid_reg;
    logic       out_kind_reg;
    logic       out_bit_reg;
    logic       out_last_reg;

    logic       accept;
    logic       can_emit;
    logic       emit;
    logic       emit_kind;
    logic       emit_bit;
    logic       emit_last;
    logic [7:0] prob_in;
    logic [7:0] prob_sat;

    dp_cmd_t    cmd;
    dp_stat_t   stat;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;

    // an output slot is free when empty or being drained this cycle
    assign can_emit = !out_valid_reg || m_axis_tready;

    // probability clamped to 1..128 so the split stays inside the range
    assign prob_in  = s_axis_tdata[7:0];
    assign prob_sat = (prob_in < PROB_MIN) ? PROB_MIN :
                      (prob_in > PROB_MAX) ? PROB_MAX : prob_in;

    bae_dpath u_dpath (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .prob   (prob_reg),
        .symbol (symbol_reg),
        .stat   (stat)
    );

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = DP_HOLD;
        emit       = 1'b0;
        emit_kind  = KIND_BIT;
        emit_bit   = 1'b0;
        emit_last  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (s_axis_tuser)
                        OP_START:
                        begin
                            cmd = DP_START;
                        end
                        OP_FLUSH:
                        begin
                            cnt_next   = 4'd0;
                            state_next = ST_FLUSH;
                        end
                        OP_ENCODE:
                        begin
                            state_next = ST_SPLIT;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_SPLIT:
            begin
                // a carry needs the output slot before the state moves on
                if (!stat.carry || can_emit)
                begin
                    cmd        = DP_SPLIT;
                    emit       = stat.carry;
                    emit_kind  = KIND_CARRY;
                    emit_last  = !stat.split_small;
                    cnt_next   = stat.carry ? 4'd1 : 4'd0;
                    state_next = stat.split_small ? ST_RENORM : ST_IDLE;
                end
            end
            ST_RENORM:
            begin
                if (can_emit)
                begin
                    cmd       = DP_RENORM;
                    emit      = 1'b1;
                    emit_bit  = stat.msb;
                    emit_last = !stat.shift_small || (cnt_reg == RES_LAST);
                    cnt_next  = cnt_reg + 4'd1;
                    if (emit_last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_FLUSH:
            begin
                // twelve rotations bring low back to where it was
                if (can_emit)
                begin
                    cmd       = DP_ROTATE;
                    emit      = 1'b1;
                    emit_bit  = stat.msb;
                    emit_last = (cnt_reg == FLUSH_LAST);
                    cnt_next  = cnt_reg + 4'd1;
                    if (emit_last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= 4'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            prob_reg   <= prob_sat;
            symbol_reg <= s_axis_tdata[8];
        end
        if (emit)
        begin
            out_kind_reg <= emit_kind;
            out_bit_reg  <= emit_bit;
            out_last_reg <= emit_last;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {7'd0, out_bit_reg};
    assign m_axis_tuser  = out_kind_reg;
    assign m_axis_tlast  = out_last_reg;

endmodule

### tb/binary_arithmetic_encoder_unit_tb.sv
module binary_arithmetic_encoder_unit_tb;
    import bae_pkg::*;

    // opcode with no function, the block drops it
    localparam logic [1:0]  OP_UNUSED  = 2'd3;
    // renormalisation stops once the range reaches half scale
    localparam logic [11:0] RANGE_HALF = 12'd2048;

    localparam int N_DIR        = 22;
    localparam int TOTAL_ITEMS  = 460;   // sent items, directed rows included, after which no new random run starts
    localparam int QUIET_FROM   = 410;   // no idling on either side from here on
    localparam int LONG_HOLD    = 300;   // receiver hold-off that backs up the input
    localparam int DRAIN_CYCLES = 40;    // extra wait once all awaited results have arrived

    // one stimulus row; typed rows carry their own hand-written result
    typedef struct packed {
        logic [1:0]  op;
        logic [7:0]  prob;
        logic        sym;
        logic        typed;
        logic [3:0]  nres;   // typed result count
        logic [11:0] bits;   // typed coded bits, msb first
    } stim_row_t;

    // one result transfer as seen on the master side
    typedef struct packed {
        logic kind;
        logic obit;
        logic last;
    } coded_res_t;

    // directed table: extremes of prob, both flags, saturation, every opcode
    localparam stim_row_t DIR_ROWS [N_DIR] = '{
        '{OP_FLUSH,  8'd0,   1'b0, 1'b1, 4'd12, 12'h000},   // low is zero after reset
        '{OP_UNUSED, 8'd255, 1'b1, 1'b1, 4'd0,  12'h000},   // dropped, nothing out
        '{OP_ENCODE, 8'd128, 1'b1, 1'b0, 4'd0,  12'h000},
        '{OP_ENCODE, 8'd128, 1'b0, 1'b0, 4'd0,  12'h000},
        '{OP_ENCODE, 8'd1,   1'b0, 1'b0, 4'd0,  12'h000},   // tiny upper part, long renorm
        '{OP_ENCODE, 8'd1,   1'b1, 1'b0, 4'd0,  12'h000},
        '{OP_ENCODE, 8'd0,   1'b0, 1'b0, 4'd0,  12'h000},   // saturates up to 1
        '{OP_ENCODE, 8'd255, 1'b0, 1'b0, 4'd0,  12'h000},   // saturates down to 128
        '{OP_ENCODE, 8'd129, 1'b1, 1'b0, 4'd0,  12'h000},
        '{OP_ENCODE, 8'd64,  1'b0, 1'b0, 4'd0,  12'h000},
        '{OP_ENCODE, 8'd100, 1'b0, 1'b0, 4'd0,  12'h000},
        '{OP_ENCODE, 8'd127, 1'b0, 1'b0, 4'd0,  12'h000},
        '{OP_ENCODE, 8'd2,   1'b0, 1'b0, 4'd0,  12'h000},
        '{OP_FLUSH,  8'd0,   1'b0, 1'b0, 4'd0,  12'h000},
        '{OP_ENCODE, 8'd85,  1'b1, 1'b0, 4'd0,  12'h000},
        '{OP_ENCODE, 8'd170, 1'b0, 1'b0, 4'd0,  12'h000},
        '{OP_FLUSH,  8'd255, 1'b1, 1'b0, 4'd0,  12'h000},
        '{OP_START,  8'd0,   1'b0, 1'b1, 4'd0,  12'h000},   // new run, nothing out
        '{OP_FLUSH,  8'd0,   1'b0, 1'b1, 4'd12, 12'h000},   // low cleared by start
        '{OP_UNUSED, 8'd0,   1'b0, 1'b1, 4'd0,  12'h000},
        '{OP_ENCODE, 8'd1,   1'b0, 1'b0, 4'd0,  12'h000},
        '{OP_FLUSH,  8'd0,   1'b0, 1'b0, 4'd0,  12'h000}
    };

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata;    // prob [7:0], symbol [8], zero fill
    logic [1:0]  s_axis_tuser;    // opcode [1:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [7:0]  m_axis_tdata;    // out_bit [0], zero fill
    logic        m_axis_tuser;    // kind [0]
    logic        m_axis_tlast;

    // row currently offered, moves with the slave-side transfer
    stim_row_t   cur_row;

    // predicted coder state
    logic [11:0] range_st;
    logic [11:0] low_st;

    // coded results still to arrive, oldest first
    coded_res_t  awaited_bits[$];

    int          fail_count = 0;
    int          items_sent = 0;
    int          idle_rate = 2;       // 0 gives a stretch with no sender gaps
    bit          quiet = 1'b0;
    bit          hold_req = 1'b0;
    bit          hold_done = 1'b0;

    binary_arithmetic_encoder_unit uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // 8 unit period
    initial clk = 1'b0;
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // generous overall limit, several times the slowest legal run
    initial
    begin
        #4000000;
        $display("status: fail");
        $finish;
    end

    task automatic note_fail(input string msg);
        fail_count++;
        if (fail_count <= 10)
            $display("%s", msg);
    endtask

    // advance the predicted coder by one item, queue what it should emit
    task automatic code_item(input logic [1:0] op, input logic [7:0] p_in,
                             input logic sym, input bit keep);
        logic [7:0]  p;
        int          k;
        int          q;
        logic [11:0] rest;
        logic [12:0] sum;
        coded_res_t  r;
        coded_res_t  made[$];
        if (op == OP_START)
        begin
            range_st = RANGE_FULL;
            low_st   = LOW_RESET;
        end
        else if (op == OP_FLUSH)
        begin
            // low window goes out msb first, state untouched
            for (int i = 11; i >= 0; i--)
            begin
                r = '{KIND_BIT, low_st[i], 1'b0};
                made.push_back(r);
            end
        end
        else if (op == OP_ENCODE)
        begin
            p = p_in;
            if (p < PROB_MIN)
                p = PROB_MIN;
            if (p > PROB_MAX)
                p = PROB_MAX;
            // k from the top range bits with bit 7 folded in
            k = int'(range_st[11:8] | {3'b000, range_st[7]});
            q = k * int'(p);
            rest = range_st - q[11:0];
            if (sym)
                range_st = rest;
            else
            begin
                sum = {1'b0, low_st} + {1'b0, rest};
                if (sum[12])
                begin
                    r = '{KIND_CARRY, 1'b0, 1'b0};
                    made.push_back(r);
                end
                low_st   = sum[11:0];
                range_st = q[11:0];
            end
            // renormalise, one coded bit per doubling
            while (range_st < RANGE_HALF && range_st != 12'd0 && made.size() < 12)
            begin
                r = '{KIND_BIT, low_st[11], 1'b0};
                made.push_back(r);
                low_st   = {low_st[10:0], 1'b0};
                range_st = {range_st[10:0], 1'b0};
            end
        end
        if (made.size() > 0)
            made[made.size() - 1].last = 1'b1;
        if (keep)
            foreach (made[i])
                awaited_bits.push_back(made[i]);
    endtask

    // predict on every accepted input transfer, check every result transfer
    always @(posedge clk)
    begin : watch
        coded_res_t r;
        coded_res_t want;
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                // typed rows bring their own result, the predictor only tracks state
                code_item(s_axis_tuser, s_axis_tdata[7:0], s_axis_tdata[8], !cur_row.typed);
                if (cur_row.typed)
                    for (int i = 0; i < int'(cur_row.nres); i++)
                    begin
                        r = '{KIND_BIT, cur_row.bits[11 - i], i == int'(cur_row.nres) - 1};
                        awaited_bits.push_back(r);
                    end
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (awaited_bits.size() == 0)
                    note_fail($sformatf("unexpected result: kind %0b bit %0b last %0b",
                                        m_axis_tuser, m_axis_tdata[0], m_axis_tlast));
                else
                begin
                    want = awaited_bits.pop_front();
                    if (m_axis_tuser !== want.kind || m_axis_tdata[0] !== want.obit
                        || m_axis_tlast !== want.last)
                        note_fail($sformatf(
                            "result mismatch: expected kind %0b bit %0b last %0b, got %0b %0b %0b",
                            want.kind, want.obit, want.last,
                            m_axis_tuser, m_axis_tdata[0], m_axis_tlast));
                end
            end
        end
    end

    // offer one item, with an occasional gap before it, until the transfer is taken
    task automatic offer_item(input stim_row_t row);
        int gap;
        if (!quiet && !(hold_req && !hold_done) && $urandom_range(1, 6) <= idle_rate)
        begin
            gap = $urandom_range(1, 16);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'd0, row.sym, row.prob};
        s_axis_tuser  <= row.op;
        cur_row       <= row;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        if (row.op != OP_UNUSED)
            items_sent++;
        if (items_sent >= QUIET_FROM)
            quiet = 1'b1;
    endtask

    // receiver: random stall bursts, one long hold-off, steady ready at the end
    initial
    begin
        m_axis_tready = 1'b0;
        while (rst_n !== 1'b1)
            @(posedge clk);
        forever
        begin
            if (hold_req && !hold_done)
            begin
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                hold_done = 1'b1;
            end
            else if (!quiet && $urandom_range(0, 4) == 0)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge clk);
            end
            else
            begin
                m_axis_tready <= 1'b1;
                repeat ($urandom_range(1, 24)) @(posedge clk);
            end
        end
    end

    // sender: reset, directed table, random coding runs, drain, verdict
    initial
    begin
        stim_row_t row;
        int        run_len;
        int        pick;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = OP_ENCODE;
        cur_row       = '0;
        range_st      = RANGE_FULL;
        low_st        = LOW_RESET;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (DIR_ROWS[i])
            offer_item(DIR_ROWS[i]);

        // long receiver hold-off while items keep coming
        hold_req = 1'b1;

        while (items_sent < TOTAL_ITEMS)
        begin
            idle_rate = $urandom_range(0, 3);
            row = '0;
            if ($urandom_range(0, 9) == 0)
            begin
                // noise: any opcode, any field content
                row.op   = 2'($urandom_range(0, 3));
                row.prob = 8'($urandom_range(0, 255));
                row.sym  = 1'($urandom_range(0, 1));
                offer_item(row);
            end
            else
            begin
                // well-formed run: start, a string of encodes, flush
                row.op   = OP_START;
                row.prob = 8'($urandom_range(0, 255));
                row.sym  = 1'($urandom_range(0, 1));
                offer_item(row);
                run_len = $urandom_range(3, 40);
                repeat (run_len)
                begin
                    row.op = OP_ENCODE;
                    pick = $urandom_range(0, 15);
                    // skewed probabilities drive long renorms and carries
                    if (pick == 0)
                        row.prob = 8'd0;
                    else if (pick == 1)
                        row.prob = 8'($urandom_range(129, 255));
                    else if (pick <= 4)
                        row.prob = 8'($urandom_range(1, 4));
                    else if (pick <= 7)
                        row.prob = 8'($urandom_range(120, 128));
                    else
                        row.prob = 8'($urandom_range(1, 128));
                    row.sym = 1'($urandom_range(0, 1));
                    offer_item(row);
                end
                row.op   = OP_FLUSH;
                row.prob = 8'($urandom_range(0, 255));
                row.sym  = 1'($urandom_range(0, 1));
                offer_item(row);
            end
        end

        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (awaited_bits.size() != 0)
            @(posedge clk);
        // anything late or extra still gets caught by the checker
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
